// File: design/amsup_pkg.sv
// Package: shared types, codes and constants of the autopilot mode supervisor
package amsup_pkg;

  localparam int HEADING_WIDTH = 16;
  localparam int HEADING_OUT_W = 16;
  localparam int CFG_INDEX_W   = 4;
  localparam int CFG_DATA_W    = 12;
  localparam int COUNT_W       = 8;

  typedef enum logic [1:0] {
    MODE_MANUAL = 2'd0,
    MODE_AUTO   = 2'd1,
    MODE_EXIT   = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    MOT_NONE     = 3'd0,
    MOT_FORWARD  = 3'd1,
    MOT_BACKWARD = 3'd2,
    MOT_LEFT     = 3'd3,
    MOT_RIGHT    = 3'd4
  } motion_t;

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_RETRY_LIMIT  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_RETRY_LIMIT = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SKIPPED_STEP_LIMIT = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DETECT_MISS_LIMIT  = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_STEADY_STEP_LIMIT  = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_TOLERANCE    = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_TOLERANCE   = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_ABANDON_ANGLE      = 4'd7;

  // Key codes (ASCII)
  localparam logic [7:0] KEY_Q_LC  = 8'h71;
  localparam logic [7:0] KEY_Q_UC  = 8'h51;
  localparam logic [7:0] KEY_E_LC  = 8'h65;
  localparam logic [7:0] KEY_E_UC  = 8'h45;
  localparam logic [7:0] KEY_W_LC  = 8'h77;
  localparam logic [7:0] KEY_W_UC  = 8'h57;
  localparam logic [7:0] KEY_A_LC  = 8'h61;
  localparam logic [7:0] KEY_A_UC  = 8'h41;
  localparam logic [7:0] KEY_S_LC  = 8'h73;
  localparam logic [7:0] KEY_S_UC  = 8'h53;
  localparam logic [7:0] KEY_D_LC  = 8'h64;
  localparam logic [7:0] KEY_D_UC  = 8'h44;
  localparam logic [7:0] KEY_SPACE = 8'd32;
  localparam logic [7:0] KEY_ESC   = 8'd27;

  // Reset, fallback and automatic-mode values
  localparam logic [4:0] SPEED_RESET      = 5'd20;
  localparam logic [4:0] SPEED_AUTO_TURN  = 5'd1;
  localparam logic [4:0] SPEED_AUTO_AHEAD = 5'd10;
  localparam logic [2:0] TURN_STEP_RESET  = 3'd5;
  localparam logic [2:0] TURN_STEP_AUTO   = 3'd1;

  typedef struct packed {
    logic [7:0]  angle_retry_limit;
    logic [7:0]  offset_retry_limit;
    logic [7:0]  skipped_step_limit;
    logic [7:0]  detect_miss_limit;
    logic [7:0]  steady_step_limit;
    logic [6:0]  angle_tolerance;
    logic [11:0] offset_tolerance;
    logic [7:0]  abandon_angle;
  } cfg_t;

  typedef struct packed {
    mode_t                    mode;
    motion_t                  motion;
    logic [HEADING_WIDTH-1:0] heading;
    logic [4:0]               speed;
    logic [2:0]               turn_step;
    logic [COUNT_W-1:0]       angle_retries;
    logic [COUNT_W-1:0]       offset_retries;
    logic [COUNT_W-1:0]       skipped_steps;
    logic [COUNT_W-1:0]       detect_misses;
    logic [COUNT_W-1:0]       steady_steps;
  } state_t;

  typedef struct packed {
    logic signed [9:0]  angle_error;
    logic signed [12:0] offset_error;
    logic               too_few_segments;
    logic [7:0]         key_code;
    logic               escape_polled;
  } in_word_t;

  // Saturating increment of a supervisor counter
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    sat_inc = (&c) ? c : c + 1'b1;
  endfunction

endpackage

// File: design/amsup_in_if.sv
// Interface: input word channel (frame measurements and key code)
interface amsup_in_if;
  logic               valid;
  logic               ready;
  logic signed [9:0]  angle_error;
  logic signed [12:0] offset_error;
  logic               too_few_segments;
  logic [7:0]         key_code;
  logic               escape_polled;

  modport source (output valid, angle_error, offset_error, too_few_segments, key_code,
                  escape_polled, input ready);
  modport sink (input valid, angle_error, offset_error, too_few_segments, key_code,
                escape_polled, output ready);
endinterface

// File: design/amsup_out_if.sv
// Interface: result word channel (mode, motion, heading, speed, turn step, fallback)
interface amsup_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode_now;
  logic [2:0]         motion_now;
  logic signed [15:0] heading_now;
  logic [4:0]         speed_now;
  logic [2:0]         turn_step_now;
  logic               fell_back;

  modport source (output valid, mode_now, motion_now, heading_now, speed_now, turn_step_now,
                  fell_back, input ready);
  modport sink (input valid, mode_now, motion_now, heading_now, speed_now, turn_step_now,
                fell_back, output ready);
endinterface

// File: design/amsup_cfg_if.sv
// Interface: configuration write channel
interface amsup_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [11:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/amsup_cfg_regs.sv
// Configuration register bank with reset values and width truncation on write
module amsup_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 wr_en,
  input  logic [amsup_pkg::CFG_INDEX_W-1:0]    wr_index,
  input  logic [amsup_pkg::CFG_DATA_W-1:0]     wr_data,
  output amsup_pkg::cfg_t                      cfg
);
  import amsup_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_ANGLE_RETRY_LIMIT:  cfg_nxt.angle_retry_limit  = wr_data[7:0];
        REG_OFFSET_RETRY_LIMIT: cfg_nxt.offset_retry_limit = wr_data[7:0];
        REG_SKIPPED_STEP_LIMIT: cfg_nxt.skipped_step_limit = wr_data[7:0];
        REG_DETECT_MISS_LIMIT:  cfg_nxt.detect_miss_limit  = wr_data[7:0];
        REG_STEADY_STEP_LIMIT:  cfg_nxt.steady_step_limit  = wr_data[7:0];
        REG_ANGLE_TOLERANCE:    cfg_nxt.angle_tolerance    = wr_data[6:0];
        REG_OFFSET_TOLERANCE:   cfg_nxt.offset_tolerance   = wr_data[11:0];
        REG_ABANDON_ANGLE:      cfg_nxt.abandon_angle      = wr_data[7:0];
        default:                cfg_nxt = cfg_r;  // drop writes past the list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.angle_retry_limit  <= 8'd70;
      cfg_r.offset_retry_limit <= 8'd70;
      cfg_r.skipped_step_limit <= 8'd10;
      cfg_r.detect_miss_limit  <= 8'd10;
      cfg_r.steady_step_limit  <= 8'd10;
      cfg_r.angle_tolerance    <= 7'd5;
      cfg_r.offset_tolerance   <= 12'd90;
      cfg_r.abandon_angle      <= 8'd45;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: design/amsup_step.sv
// Next-state logic for one frame: key decode, automatic step, limit checks, escape
module amsup_step (
  input  amsup_pkg::state_t   state_i,
  input  amsup_pkg::cfg_t     cfg,
  input  amsup_pkg::in_word_t word_i,
  output amsup_pkg::state_t   state_nxt,
  output logic                fell_back
);
  import amsup_pkg::*;

  logic [9:0]  ang_u;
  logic [12:0] off_u;
  logic [9:0]  ang_mag;
  logic [12:0] off_mag;
  state_t      n;
  logic        back;

  assign ang_u   = word_i.angle_error;
  assign off_u   = word_i.offset_error;
  assign ang_mag = ang_u[9] ? (~ang_u + 10'd1) : ang_u;
  assign off_mag = off_u[12] ? (~off_u + 13'd1) : off_u;

  always_comb begin
    n    = state_i;
    back = 1'b0;
    if (state_i.mode != MODE_EXIT) begin
      if (word_i.too_few_segments) begin
        n.detect_misses = sat_inc(n.detect_misses);
      end

      if (state_i.mode == MODE_AUTO) begin
        if (ang_mag >= {2'b00, cfg.abandon_angle}) begin
          n.skipped_steps = sat_inc(n.skipped_steps);
        end else begin
          n.speed     = SPEED_AUTO_TURN;
          n.turn_step = TURN_STEP_AUTO;
          if (ang_u != 10'd0) begin
            // steer one degree against the error
            if (!ang_u[9]) begin
              n.heading = n.heading - HEADING_WIDTH'(1);
            end else begin
              n.heading = n.heading + HEADING_WIDTH'(1);
            end
            if (ang_mag > {3'b000, cfg.angle_tolerance}) begin
              n.steady_steps  = '0;
              n.angle_retries = sat_inc(n.angle_retries);
            end else begin
              n.angle_retries = '0;
              n.steady_steps  = sat_inc(n.steady_steps);
            end
          end
          if (off_mag > {1'b0, cfg.offset_tolerance}) begin
            n.steady_steps   = '0;
            n.motion         = off_u[12] ? MOT_RIGHT : MOT_LEFT;
            n.offset_retries = sat_inc(n.offset_retries);
          end else begin
            n.offset_retries = '0;
            n.steady_steps   = sat_inc(n.steady_steps);
            n.speed          = SPEED_AUTO_AHEAD;
            n.motion         = MOT_FORWARD;
          end
        end
      end else begin
        unique case (word_i.key_code) inside
          KEY_Q_LC, KEY_Q_UC: begin
            n.heading = n.heading - HEADING_WIDTH'(n.turn_step);
            n.motion  = MOT_NONE;
          end
          KEY_E_LC, KEY_E_UC: begin
            n.heading = n.heading + HEADING_WIDTH'(n.turn_step);
            n.motion  = MOT_NONE;
          end
          KEY_W_LC, KEY_W_UC: n.motion = MOT_FORWARD;
          KEY_A_LC, KEY_A_UC: n.motion = MOT_LEFT;
          KEY_S_LC, KEY_S_UC: n.motion = MOT_BACKWARD;
          KEY_D_LC, KEY_D_UC: n.motion = MOT_RIGHT;
          KEY_SPACE:          n.mode   = MODE_AUTO;
          KEY_ESC:            n.mode   = MODE_EXIT;
          default:            n.motion = MOT_NONE;
        endcase
      end

      // limit checks
      if (n.angle_retries > cfg.angle_retry_limit) begin
        n.angle_retries = '0;
        back            = 1'b1;
      end
      if (n.offset_retries > cfg.offset_retry_limit) begin
        n.offset_retries = '0;
        back             = 1'b1;
      end
      if (n.skipped_steps > cfg.skipped_step_limit) begin
        n.skipped_steps = '0;
        back            = 1'b1;
      end
      if (n.detect_misses > cfg.detect_miss_limit) begin
        n.detect_misses = '0;
        back            = 1'b1;
      end
      if (n.steady_steps > cfg.steady_step_limit) begin
        n.angle_retries  = '0;
        n.offset_retries = '0;
      end
      if (back) begin
        n.motion    = MOT_NONE;
        n.mode      = MODE_MANUAL;
        n.speed     = SPEED_RESET;
        n.turn_step = TURN_STEP_RESET;
      end

      if (n.mode == MODE_AUTO && word_i.escape_polled) begin
        n.mode      = MODE_MANUAL;
        n.speed     = SPEED_RESET;
        n.turn_step = TURN_STEP_RESET;
      end
    end
  end

  assign state_nxt = n;
  assign fell_back = back;

endmodule

// File: design/autopilot_mode_supervisor.sv
// Top level: autopilot mode supervisor with input register, state and result register
//
// Usage:
//   in_chan  - one word per video frame: angle error, lateral error, too-few-segments
//              flag, key code and escape flag. Accepted when valid and ready are high.
//   out_chan - one result word per input word: mode, motion, heading (low 16 bits),
//              speed, turn step and a fallback flag. Taken when valid and ready are high.
//   cfg_chan - register writes (index 0..7, data truncated to the register's width);
//              always ready, indexes past the list are ignored. Write only while idle.
// Path: a word accepted on in_chan is held in the input register, processed by the
//   single-pass step logic and held in the result register that drives out_chan.
// Throughput: one word per cycle while out_chan is ready; the state update of one word completes in the same
//   cycle that the step logic reads it, so words follow back to back.
// Reset (rst_n low, synchronous): mode manual, motion none, heading 0, speed 20,
//   turn step 5, all counters 0, configuration back to its reset values, both
//   channels empty.
// Stall: while out_chan is held, the result register keeps its word, the input
//   register fills once more and then in_chan drops ready until the result is taken.
module autopilot_mode_supervisor (
  input logic    clk,
  input logic    rst_n,
  amsup_in_if.sink   in_chan,
  amsup_out_if.source out_chan,
  amsup_cfg_if.sink  cfg_chan
);
  import amsup_pkg::*;

  cfg_t     cfg;
  state_t   state_r;
  state_t   state_nxt;
  in_word_t in_word_r;
  logic     in_v_r;
  logic     out_v_r;
  logic     fell_back_nxt;
  logic     step_go;

  // result register payload
  logic [1:0]                 mode_now_r;
  logic [2:0]                 motion_now_r;
  logic [HEADING_OUT_W-1:0]   heading_now_r;
  logic [4:0]                 speed_now_r;
  logic [2:0]                 turn_step_now_r;
  logic                       fell_back_r;

  // configuration: always ready, writes land at once
  assign cfg_chan.ready = 1'b1;

  amsup_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_chan.valid),
    .wr_index (cfg_chan.index),
    .wr_data  (cfg_chan.data),
    .cfg      (cfg)
  );

  // advance the input word when the result register is free or being emptied
  assign step_go       = in_v_r && (!out_v_r || out_chan.ready);
  assign in_chan.ready = !in_v_r || step_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      in_v_r <= 1'b1;
    end else if (step_go) begin
      in_v_r <= 1'b0;
    end
  end

  // hold the input word; payload needs no reset
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_word_r.angle_error      <= in_chan.angle_error;
      in_word_r.offset_error     <= in_chan.offset_error;
      in_word_r.too_few_segments <= in_chan.too_few_segments;
      in_word_r.key_code         <= in_chan.key_code;
      in_word_r.escape_polled    <= in_chan.escape_polled;
    end
  end

  amsup_step u_step (
    .state_i   (state_r),
    .cfg       (cfg),
    .word_i    (in_word_r),
    .state_nxt (state_nxt),
    .fell_back (fell_back_nxt)
  );

  // supervisor state: commit only when the word moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode           <= MODE_MANUAL;
      state_r.motion         <= MOT_NONE;
      state_r.heading        <= '0;
      state_r.speed          <= SPEED_RESET;
      state_r.turn_step      <= TURN_STEP_RESET;
      state_r.angle_retries  <= '0;
      state_r.offset_retries <= '0;
      state_r.skipped_steps  <= '0;
      state_r.detect_misses  <= '0;
      state_r.steady_steps   <= '0;
    end else if (step_go) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step_go) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      mode_now_r      <= state_nxt.mode;
      motion_now_r    <= state_nxt.motion;
      heading_now_r   <= HEADING_OUT_W'(state_nxt.heading);
      speed_now_r     <= state_nxt.speed;
      turn_step_now_r <= state_nxt.turn_step;
      fell_back_r     <= fell_back_nxt;
    end
  end

  assign out_chan.valid         = out_v_r;
  assign out_chan.mode_now      = mode_now_r;
  assign out_chan.motion_now    = motion_now_r;
  assign out_chan.heading_now   = signed'(heading_now_r);
  assign out_chan.speed_now     = speed_now_r;
  assign out_chan.turn_step_now = turn_step_now_r;
  assign out_chan.fell_back     = fell_back_r;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the autopilot mode supervisor: random stimulus against a predictor
module tb_top;
  import amsup_pkg::*;

  // Run limits and pacing
  localparam int CYCLE_LIMIT  = 500_000;
  localparam int LONG_HOLD    = 300;
  localparam int REPORT_LIMIT = 10;
  localparam int PHASE_WORDS  = 130;
  localparam int PHASE_COUNT  = 7;

  // An index past the register list; the block must ignore writes to it
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 4'd15;
  // A key with no meaning of its own
  localparam logic [7:0] KEY_NONE = 8'h00;

  // Register settings: values at reset, all at their floor, all at their ceiling
  localparam cfg_t CFG_AT_RESET = '{8'd70, 8'd70, 8'd10, 8'd10, 8'd10, 7'd5, 12'd90, 8'd45};
  localparam cfg_t CFG_FLOOR    = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 7'd0, 12'd0, 8'd1};
  localparam cfg_t CFG_CEILING  = '{8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 7'd90, 12'd4095,
                                    8'd180};

  // One status word as the block reports it after each frame
  typedef struct packed {
    mode_t      mode;
    motion_t    motion;
    logic [15:0] heading;
    logic [4:0] speed;
    logic [2:0] turn_step;
    logic       fell_back;
  } status_word_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #1 clk = ~clk;

  amsup_in_if  in_if ();
  amsup_out_if out_if ();
  amsup_cfg_if cfg_if ();

  autopilot_mode_supervisor u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // Predictor's own copy of the supervisor state and of the register file
  state_t sup_state;
  cfg_t   cfg_mirror;

  // Status words still owed by the block, oldest first
  status_word_t predicted_status[$];
  // Frame words waiting for the driver
  in_word_t     pending_words[$];
  in_word_t     word_on_bus;

  int words_queued   = 0;
  int words_accepted = 0;
  int error_count    = 0;
  int cycle_count    = 0;

  // Traffic shaping, set per phase by the stimulus process
  bit src_idle_on        = 1'b1;
  bit sink_idle_on       = 1'b1;
  bit quiet_tail         = 1'b0;
  int long_hold_requests = 0;

  logic [7:0] steer_keys [12] = '{KEY_Q_LC, KEY_Q_UC, KEY_E_LC, KEY_E_UC, KEY_W_LC, KEY_W_UC,
                                  KEY_A_LC, KEY_A_UC, KEY_S_LC, KEY_S_UC, KEY_D_LC, KEY_D_UC};

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Counters stick at all ones rather than wrapping
  function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // Advance the supervisor by one frame word and queue the status it must report
  function automatic void advance_supervisor(input in_word_t w);
    int           ang;
    int           off;
    int           ang_mag;
    int           off_mag;
    logic         dropped;
    status_word_t s;

    dropped = 1'b0;
    // Exit is terminal: ignore the word entirely and report the frozen state
    if (sup_state.mode != MODE_EXIT) begin
      ang     = $signed(w.angle_error);
      off     = $signed(w.offset_error);
      ang_mag = (ang < 0) ? -ang : ang;
      off_mag = (off < 0) ? -off : off;

      // Missed detections count first, whatever the mode
      if (w.too_few_segments) begin
        sup_state.detect_misses = count_up(sup_state.detect_misses);
      end

      if (sup_state.mode == MODE_AUTO) begin
        if (ang_mag >= int'(cfg_mirror.abandon_angle)) begin
          // Line too far off: abandon this step, only note it
          sup_state.skipped_steps = count_up(sup_state.skipped_steps);
        end else begin
          sup_state.speed     = SPEED_AUTO_TURN;
          sup_state.turn_step = TURN_STEP_AUTO;
          // Steer one degree against the angle error
          if (ang != 0) begin
            if (ang > 0) begin
              sup_state.heading = sup_state.heading - 1'b1;
            end else begin
              sup_state.heading = sup_state.heading + 1'b1;
            end
            if (ang_mag > int'(cfg_mirror.angle_tolerance)) begin
              sup_state.steady_steps  = '0;
              sup_state.angle_retries = count_up(sup_state.angle_retries);
            end else begin
              sup_state.angle_retries = '0;
              sup_state.steady_steps  = count_up(sup_state.steady_steps);
            end
          end
          // Lateral error: sidestep towards the line, or drive ahead when close
          if (off_mag > int'(cfg_mirror.offset_tolerance)) begin
            sup_state.steady_steps   = '0;
            sup_state.motion         = (off < 0) ? MOT_RIGHT : MOT_LEFT;
            sup_state.offset_retries = count_up(sup_state.offset_retries);
          end else begin
            sup_state.offset_retries = '0;
            sup_state.steady_steps   = count_up(sup_state.steady_steps);
            sup_state.speed          = SPEED_AUTO_AHEAD;
            sup_state.motion         = MOT_FORWARD;
          end
        end
      end else begin
        case (w.key_code)
          KEY_Q_LC, KEY_Q_UC: begin
            sup_state.heading = sup_state.heading - sup_state.turn_step;
            sup_state.motion  = MOT_NONE;
          end
          KEY_E_LC, KEY_E_UC: begin
            sup_state.heading = sup_state.heading + sup_state.turn_step;
            sup_state.motion  = MOT_NONE;
          end
          KEY_W_LC, KEY_W_UC: sup_state.motion = MOT_FORWARD;
          KEY_A_LC, KEY_A_UC: sup_state.motion = MOT_LEFT;
          KEY_S_LC, KEY_S_UC: sup_state.motion = MOT_BACKWARD;
          KEY_D_LC, KEY_D_UC: sup_state.motion = MOT_RIGHT;
          KEY_SPACE:          sup_state.mode   = MODE_AUTO;
          KEY_ESC:            sup_state.mode   = MODE_EXIT;
          default:            sup_state.motion = MOT_NONE;
        endcase
      end

      // Limit checks; any counter past its limit drops back to manual,
      // even from an exit chosen in this very frame
      if (sup_state.angle_retries > cfg_mirror.angle_retry_limit) begin
        sup_state.angle_retries = '0;
        dropped = 1'b1;
      end
      if (sup_state.offset_retries > cfg_mirror.offset_retry_limit) begin
        sup_state.offset_retries = '0;
        dropped = 1'b1;
      end
      if (sup_state.skipped_steps > cfg_mirror.skipped_step_limit) begin
        sup_state.skipped_steps = '0;
        dropped = 1'b1;
      end
      if (sup_state.detect_misses > cfg_mirror.detect_miss_limit) begin
        sup_state.detect_misses = '0;
        dropped = 1'b1;
      end
      // A long steady run forgives earlier retries
      if (sup_state.steady_steps > cfg_mirror.steady_step_limit) begin
        sup_state.angle_retries  = '0;
        sup_state.offset_retries = '0;
      end
      if (dropped) begin
        sup_state.motion    = MOT_NONE;
        sup_state.mode      = MODE_MANUAL;
        sup_state.speed     = SPEED_RESET;
        sup_state.turn_step = TURN_STEP_RESET;
      end

      // Escape leaves automatic mode but keeps the motion and is no fallback
      if (sup_state.mode == MODE_AUTO && w.escape_polled) begin
        sup_state.mode      = MODE_MANUAL;
        sup_state.speed     = SPEED_RESET;
        sup_state.turn_step = TURN_STEP_RESET;
      end
    end

    s.mode      = sup_state.mode;
    s.motion    = sup_state.motion;
    s.heading   = sup_state.heading[15:0];
    s.speed     = sup_state.speed;
    s.turn_step = sup_state.turn_step;
    s.fell_back = dropped;
    predicted_status.push_back(s);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void queue_word(input int ang, input int off, input bit few,
                                     input logic [7:0] key, input bit esc);
    in_word_t w;
    w.angle_error      = ang[9:0];
    w.offset_error     = off[12:0];
    w.too_few_segments = few;
    w.key_code         = key;
    w.escape_polled    = esc;
    pending_words.push_back(w);
    words_queued++;
  endfunction

  // Any key but the exit key, which would end the run's useful life
  function automatic logic [7:0] any_key_but_exit();
    logic [7:0] k;
    do begin
      k = 8'($urandom_range(255));
    end while (k == KEY_ESC);
    return k;
  endfunction

  function automatic logic [7:0] pick_manual_key();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5, 6: return steer_keys[$urandom_range(11)];
      7:                   return KEY_SPACE;
      default:             return any_key_but_exit();
    endcase
  endfunction

  // Angle errors cluster round zero, the tolerance and the abandon threshold
  function automatic int pick_angle();
    int mag;
    case ($urandom_range(9))
      0:          mag = 0;
      1, 2, 3, 4: mag = $urandom_range(cfg_mirror.angle_tolerance + 2);
      5, 6:       mag = int'(cfg_mirror.abandon_angle) - 2 + int'($urandom_range(3));
      7:          mag = $urandom_range(1) ? 360 : $urandom_range(360);
      default:    mag = $urandom_range(cfg_mirror.abandon_angle);
    endcase
    if (mag < 0) mag = 0;
    if (mag > 360) mag = 360;
    return $urandom_range(1) ? mag : -mag;
  endfunction

  // Lateral errors cluster round zero and the tolerance, with the odd wild one
  function automatic int pick_offset();
    int mag;
    int val;
    case ($urandom_range(9))
      0:          mag = 0;
      1, 2, 3, 4: mag = $urandom_range(cfg_mirror.offset_tolerance);
      5, 6, 7:    mag = int'(cfg_mirror.offset_tolerance) - 3 + int'($urandom_range(6));
      default:    return int'($urandom_range(8191)) - 4096;
    endcase
    if (mag < 0) mag = 0;
    if (mag > 4096) mag = 4096;
    val = $urandom_range(1) ? mag : -mag;
    if (val > 4095) val = 4095;
    return val;
  endfunction

  // Small limits most of the time so that fallbacks actually happen
  function automatic cfg_t random_setting();
    cfg_t s;
    s.angle_retry_limit  = 8'($urandom_range(1) ? $urandom_range(25) : $urandom_range(254));
    s.offset_retry_limit = 8'($urandom_range(1) ? $urandom_range(25) : $urandom_range(254));
    s.skipped_step_limit = 8'($urandom_range(1) ? $urandom_range(25) : $urandom_range(254));
    s.detect_miss_limit  = 8'($urandom_range(1) ? $urandom_range(25) : $urandom_range(254));
    s.steady_step_limit  = 8'($urandom_range(1) ? $urandom_range(25) : $urandom_range(254));
    s.angle_tolerance    = 7'($urandom_range(90));
    s.offset_tolerance   = 12'($urandom_range(1) ? $urandom_range(200) : $urandom_range(4095));
    s.abandon_angle      = 8'($urandom_range(1, 180));
    return s;
  endfunction

  // Mostly well-formed drives: enter automatic, track for a while, maybe escape.
  // The rest is manual keying, noise and broken sequences.
  function automatic void queue_random_words(input int count);
    int target;
    target = words_queued + count;
    while (words_queued < target) begin
      case ($urandom_range(9))
        0, 1: begin
          repeat ($urandom_range(1, 8)) begin
            queue_word(pick_angle(), pick_offset(), $urandom_range(7) == 0, pick_manual_key(),
                       1'($urandom_range(1)));
          end
        end
        2, 3, 4, 5, 6, 7: begin
          queue_word(pick_angle(), pick_offset(), $urandom_range(7) == 0, KEY_SPACE, 1'b0);
          repeat ($urandom_range(1, 40)) begin
            queue_word(pick_angle(), pick_offset(), $urandom_range(5) == 0, any_key_but_exit(),
                       $urandom_range(24) == 0);
          end
          if ($urandom_range(1)) begin
            queue_word(pick_angle(), pick_offset(), 1'b0, any_key_but_exit(), 1'b1);
          end
        end
        8: begin
          repeat ($urandom_range(1, 6)) begin
            queue_word(int'($urandom_range(720)) - 360, int'($urandom_range(8191)) - 4096,
                       1'($urandom_range(1)), any_key_but_exit(), 1'($urandom_range(1)));
          end
        end
        default: begin
          // enter and escape in one frame
          queue_word(pick_angle(), pick_offset(), 1'($urandom_range(1)), KEY_SPACE, 1'b1);
        end
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------

  // Drive one register write and hold until it is taken; the caller drops valid
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    cfg_if.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_ANGLE_RETRY_LIMIT:  cfg_mirror.angle_retry_limit  = value[7:0];
      REG_OFFSET_RETRY_LIMIT: cfg_mirror.offset_retry_limit = value[7:0];
      REG_SKIPPED_STEP_LIMIT: cfg_mirror.skipped_step_limit = value[7:0];
      REG_DETECT_MISS_LIMIT:  cfg_mirror.detect_miss_limit  = value[7:0];
      REG_STEADY_STEP_LIMIT:  cfg_mirror.steady_step_limit  = value[7:0];
      REG_ANGLE_TOLERANCE:    cfg_mirror.angle_tolerance    = value[6:0];
      REG_OFFSET_TOLERANCE:   cfg_mirror.offset_tolerance   = value;
      REG_ABANDON_ANGLE:      cfg_mirror.abandon_angle      = value[7:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input cfg_t s);
    write_register(REG_ANGLE_RETRY_LIMIT, 12'(s.angle_retry_limit));
    write_register(REG_OFFSET_RETRY_LIMIT, 12'(s.offset_retry_limit));
    write_register(REG_SKIPPED_STEP_LIMIT, 12'(s.skipped_step_limit));
    write_register(REG_DETECT_MISS_LIMIT, 12'(s.detect_miss_limit));
    write_register(REG_STEADY_STEP_LIMIT, 12'(s.steady_step_limit));
    write_register(REG_ANGLE_TOLERANCE, 12'(s.angle_tolerance));
    write_register(REG_OFFSET_TOLERANCE, s.offset_tolerance);
    write_register(REG_ABANDON_ANGLE, 12'(s.abandon_angle));
    cfg_if.valid <= 1'b0;
  endtask

  // Hold the sender until every accepted word has had its status checked,
  // then let the block settle before returning
  task automatic wait_until_drained();
    while (words_accepted != words_queued || predicted_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer queued words, idling in bursts between them
  // ---------------------------------------------------------------------------
  int src_gap = 0;

  always @(posedge clk) begin : drive_words
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      // A word taken at this edge advances the predictor
      if (in_if.valid && in_if.ready) begin
        advance_supervisor(word_on_bus);
        words_accepted++;
      end
      // Never withdraw a word that is still on offer
      if (!in_if.valid || in_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_if.valid <= 1'b0;
        end else if (src_idle_on && !quiet_tail && $urandom_range(7) == 0) begin
          src_gap = $urandom_range(18);
          in_if.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          word_on_bus = pending_words.pop_front();
          in_if.angle_error      <= word_on_bus.angle_error;
          in_if.offset_error     <= word_on_bus.offset_error;
          in_if.too_few_segments <= word_on_bus.too_few_segments;
          in_if.key_code         <= word_on_bus.key_code;
          in_if.escape_polled    <= word_on_bus.escape_polled;
          in_if.valid            <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: take status words, check them against the oldest prediction
  // ---------------------------------------------------------------------------
  int sink_stall       = 0;
  int long_hold_served = 0;

  always @(posedge clk) begin : collect_status
    status_word_t seen;
    status_word_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        seen.mode      = mode_t'(out_if.mode_now);
        seen.motion    = motion_t'(out_if.motion_now);
        seen.heading   = out_if.heading_now;
        seen.speed     = out_if.speed_now;
        seen.turn_step = out_if.turn_step_now;
        seen.fell_back = out_if.fell_back;
        if (predicted_status.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("status word with none owed: mode %0d motion %0d heading %0d",
                     seen.mode, seen.motion, seen.heading);
          end
        end else begin
          want = predicted_status.pop_front();
          if (seen !== want) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
              $write("status mismatch (expected/seen): mode %0d/%0d motion %0d/%0d ",
                     want.mode, seen.mode, want.motion, seen.motion);
              $display("heading %0d/%0d speed %0d/%0d turn %0d/%0d fell_back %0b/%0b",
                       want.heading, seen.heading, want.speed, seen.speed,
                       want.turn_step, seen.turn_step, want.fell_back, seen.fell_back);
            end
          end
        end
      end
      // A long hold-off lets the block fill up and push back on the sender
      if (long_hold_served != long_hold_requests) begin
        long_hold_served++;
        sink_stall = LONG_HOLD;
      end
      if (sink_stall > 0) begin
        sink_stall--;
        out_if.ready <= 1'b0;
      end else if (sink_idle_on && !quiet_tail && $urandom_range(7) == 0) begin
        sink_stall = $urandom_range(18);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin : run_stimulus
    cfg_t setting;

    cfg_if.valid           = 1'b0;
    cfg_if.index           = '0;
    cfg_if.data            = '0;

    // Predictor starts where the block's reset leaves it
    sup_state           = '0;
    sup_state.mode      = MODE_MANUAL;
    sup_state.motion    = MOT_NONE;
    sup_state.speed     = SPEED_RESET;
    sup_state.turn_step = TURN_STEP_RESET;
    cfg_mirror          = CFG_AT_RESET;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every manual key class, with wild but ignored errors and escape;
    // the first turn wraps the heading below zero
    queue_word(-360, -4096, 1'b0, KEY_Q_LC, 1'b1);
    queue_word(360, 4095, 1'b0, KEY_Q_UC, 1'b0);
    queue_word(0, 0, 1'b0, KEY_E_UC, 1'b1);
    queue_word(0, 0, 1'b0, KEY_E_LC, 1'b0);
    queue_word(0, 0, 1'b0, KEY_W_LC, 1'b0);
    queue_word(0, 0, 1'b0, KEY_A_UC, 1'b0);
    queue_word(0, 0, 1'b0, KEY_S_UC, 1'b0);
    queue_word(0, 0, 1'b0, KEY_D_LC, 1'b0);
    queue_word(0, 0, 1'b0, KEY_NONE, 1'b0);
    queue_word(0, 0, 1'b0, 8'hFF, 1'b0);
    // Automatic tracking: dead on, abandoned, retry with sidestep right,
    // both errors exactly at tolerance, abandon boundary, sidestep left, escape
    queue_word(0, 0, 1'b0, KEY_SPACE, 1'b0);
    queue_word(0, 0, 1'b0, KEY_NONE, 1'b0);
    queue_word(-360, -4096, 1'b0, KEY_NONE, 1'b0);
    queue_word(44, -91, 1'b0, KEY_NONE, 1'b0);
    queue_word(-5, 90, 1'b0, KEY_NONE, 1'b0);
    queue_word(45, 0, 1'b0, KEY_NONE, 1'b0);
    queue_word(3, 4095, 1'b0, KEY_NONE, 1'b0);
    queue_word(0, 0, 1'b0, KEY_NONE, 1'b1);
    // Enter automatic and escape in the same frame
    queue_word(0, 0, 1'b0, KEY_SPACE, 1'b1);
    wait_until_drained();

    // With no tolerance for missed detections a fallback fires even in manual
    // mode and even in the frame that chose exit; the unused index is dropped
    write_register(REG_DETECT_MISS_LIMIT, '0);
    write_register(REG_UNUSED, '1);
    cfg_if.valid <= 1'b0;
    queue_word(0, 0, 1'b1, KEY_ESC, 1'b0);
    queue_word(0, 0, 1'b1, KEY_W_LC, 1'b0);

    // Random phases, each under a fresh register setting
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_until_drained();
      case (phase)
        0:       setting = CFG_AT_RESET;
        1:       setting = CFG_FLOOR;
        2:       setting = CFG_CEILING;
        default: setting = random_setting();
      endcase
      load_settings(setting);
      src_idle_on  <= (phase != 5);
      sink_idle_on <= (phase != 4);
      quiet_tail   <= (phase == PHASE_COUNT - 1);
      if (phase == 2) begin
        long_hold_requests <= long_hold_requests + 1;
      end
      if (phase == 3) begin
        // hold the sender mid-phase until the block has emptied
        queue_random_words(PHASE_WORDS / 2);
        wait_until_drained();
        queue_random_words(PHASE_WORDS / 2);
      end else begin
        queue_random_words(PHASE_WORDS);
      end
    end

    // Close out: leave automatic if needed, choose exit, then show that
    // nothing moves the block any more
    wait_until_drained();
    queue_word(0, 0, 1'b0, KEY_NONE, 1'b1);
    queue_word(0, 0, 1'b0, KEY_ESC, 1'b0);
    queue_word(pick_angle(), pick_offset(), 1'b1, KEY_SPACE, 1'b1);
    queue_word(pick_angle(), pick_offset(), 1'b1, KEY_Q_LC, 1'b0);
    queue_word(pick_angle(), pick_offset(), 1'b0, KEY_W_UC, 1'b1);
    queue_word(pick_angle(), pick_offset(), 1'b1, KEY_ESC, 1'b0);
    wait_until_drained();
    repeat (8) @(posedge clk);

    if (error_count == 0 && predicted_status.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
design/amsup_pkg.sv
design/amsup_in_if.sv
design/amsup_out_if.sv
design/amsup_cfg_if.sv
design/amsup_cfg_regs.sv
design/amsup_step.sv
design/autopilot_mode_supervisor.sv
tb/tb_top.sv
